FILE: rtl/cckb_pkg.sv
// Package: types, constants and register indexes of the clipped colour-key blit core
`default_nettype none
package cckb_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int PIXEL_BITS = 32;

	localparam int REG_W   = 13;
	localparam int PITCH_W = 14;
	localparam int PIX_W   = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_SEL_W = 3;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int SIDX_W  = 24;
	localparam int SADR_W  = 25;

	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

	localparam logic [IDX_SEL_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
	localparam logic [IDX_SEL_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
	localparam logic [IDX_SEL_W-1:0] REG_SCREEN_WIDTH   = 3'd2;
	localparam logic [IDX_SEL_W-1:0] REG_SCREEN_HEIGHT  = 3'd3;
	localparam logic [IDX_SEL_W-1:0] REG_SCANLINE_PITCH = 3'd4;
	localparam logic [IDX_SEL_W-1:0] REG_KEY_COLOR      = 3'd5;

	typedef struct packed {
		logic [11:0]      rect_src_x;
		logic [11:0]      rect_src_y;
		logic [12:0]      rect_width;
		logic [12:0]      rect_height;
		logic [11:0]      dest_x;
		logic [11:0]      dest_y;
		logic [11:0]      offset_x;
		logic [11:0]      offset_y;
		logic [PIX_W-1:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic              inside_clip;
		logic              write_enable;
		logic [SIDX_W-1:0] source_index;
		logic [SADR_W-1:0] screen_address;
		logic [PIX_W-1:0]  pixel_data;
	} out_item_t;

	typedef struct packed {
		logic [REG_W-1:0]   source_width;
		logic [REG_W-1:0]   source_height;
		logic [REG_W-1:0]   screen_width;
		logic [REG_W-1:0]   screen_height;
		logic [PITCH_W-1:0] scanline_pitch;
		logic [PIX_W-1:0]   key_color;
	} cfg_t;

endpackage
`default_nettype wire

FILE: rtl/cckb_calc.sv
// Per-pixel logic: double clipping, source index, screen address and key test
`default_nettype none
module cckb_calc (
	input  wire cckb_pkg::cfg_t      cfg,
	input  wire cckb_pkg::in_item_t  item,
	output cckb_pkg::out_item_t      result
);

	localparam int CMP_W = (cckb_pkg::REG_W > cckb_pkg::DIM_W) ? cckb_pkg::REG_W
		: cckb_pkg::DIM_W;
	localparam int EXT_W = CMP_W + 1;

	function automatic logic [EXT_W-1:0] sat_dim(input logic [cckb_pkg::REG_W-1:0] v);
		logic [CMP_W-1:0] ve;
		ve = CMP_W'(v);
		if (ve > CMP_W'(cckb_pkg::MAX_DIM))
			return EXT_W'(cckb_pkg::MAX_DIM);
		return EXT_W'(v);
	endfunction

	function automatic logic [EXT_W-1:0] clip_ext(input logic [EXT_W-1:0] start,
			input logic [EXT_W-1:0] len, input logic [EXT_W-1:0] limit);
		logic [EXT_W-1:0] stop;
		stop = start + len;
		if (start >= limit)
			return '0;
		if (stop > limit)
			stop = limit;
		return stop - start;
	endfunction

	logic [EXT_W-1:0] fw, fh, vw, vh;
	logic             hit;
	logic [12:0]      src_row, src_col, scr_row, scr_col;
	logic [25:0]      src_prod;
	logic [26:0]      scr_prod;
	logic [cckb_pkg::PIX_W-1:0] pix_m, key_m;

	always_comb begin
		fw = clip_ext(EXT_W'(item.rect_src_x), EXT_W'(item.rect_width),
			sat_dim(cfg.source_width));
		fh = clip_ext(EXT_W'(item.rect_src_y), EXT_W'(item.rect_height),
			sat_dim(cfg.source_height));
		vw = clip_ext(EXT_W'(item.dest_x), fw, sat_dim(cfg.screen_width));
		vh = clip_ext(EXT_W'(item.dest_y), fh, sat_dim(cfg.screen_height));
		hit = (EXT_W'(item.offset_x) < vw) && (EXT_W'(item.offset_y) < vh);

		src_row = 13'(item.rect_src_y) + 13'(item.offset_y);
		src_col = 13'(item.rect_src_x) + 13'(item.offset_x);
		scr_row = 13'(item.dest_y) + 13'(item.offset_y);
		scr_col = 13'(item.dest_x) + 13'(item.offset_x);
		src_prod = 26'(src_row) * 26'(cfg.source_width);
		scr_prod = 27'(scr_row) * 27'(cfg.scanline_pitch);

		pix_m = item.pixel_value & cckb_pkg::PIX_MASK;
		key_m = cfg.key_color & cckb_pkg::PIX_MASK;

		result.inside_clip    = hit;
		result.write_enable   = hit && !((key_m != '0) && (pix_m == key_m));
		result.source_index   = hit ? src_prod[23:0] + 24'(src_col) : '0;
		result.screen_address = hit ? scr_prod[24:0] + 25'(scr_col) : '0;
		result.pixel_data     = pix_m;
	end

endmodule
`default_nettype wire

FILE: rtl/clipped_color_key_blit_core.sv
// Top level: clipped colour-key blit pixel stage with registers and two-stage pipe
//
//  channel | signals                      | moves
//  req     | req_valid, req_ready, req    | one pixel item of a blit
//  rsp     | rsp_valid, rsp_ready, rsp    | one write item per pixel
//  cfg     | cfg_we, cfg_index, cfg_data  | register write, no wait
//
// One item per cycle while rsp is not stalled; each item passes the input register, then the result register.
// The multiply-add between the two registers sets the clock period.
// Reset clears the valid flags and the config registers to zero.
// A stalled rsp holds the result and back-pressures req through the pipe.
`default_nettype none
module clipped_color_key_blit_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  req_valid,
	output logic                                 req_ready,
	input  wire cckb_pkg::in_item_t              req,
	output logic                                 rsp_valid,
	input  wire                                  rsp_ready,
	output cckb_pkg::out_item_t                  rsp,
	input  wire                                  cfg_we,
	input  wire  [cckb_pkg::IDX_SEL_W-1:0]       cfg_index,
	input  wire  [cckb_pkg::CFG_W-1:0]           cfg_data
);

	cckb_pkg::cfg_t      cfg_q;
	cckb_pkg::in_item_t  item_s1;
	cckb_pkg::out_item_t result_s2;
	cckb_pkg::out_item_t result_c;
	logic                valid_s1, valid_s2;
	logic                adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cckb_pkg::REG_SOURCE_WIDTH:   cfg_q.source_width   <= cfg_data[12:0];
				cckb_pkg::REG_SOURCE_HEIGHT:  cfg_q.source_height  <= cfg_data[12:0];
				cckb_pkg::REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data[12:0];
				cckb_pkg::REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data[12:0];
				cckb_pkg::REG_SCANLINE_PITCH: cfg_q.scanline_pitch <= cfg_data[13:0];
				cckb_pkg::REG_KEY_COLOR:      cfg_q.key_color      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign adv_s1    = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			item_s1 <= req;
		if (adv_s1 && valid_s1)
			result_s2 <= result_c;
	end

	cckb_calc u_calc (
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (result_c)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = result_s2;

	a_we_needs_inside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.write_enable || rsp.inside_clip))
		else $error("write enable without inside_clip");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.inside_clip) |-> (rsp.source_index == '0
			&& rsp.screen_address == '0))
		else $error("addresses not cleared outside clip");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> valid_s1)
		else $error("accepted item lost from input register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !rsp_ready) |=> (valid_s1 && valid_s2))
		else $error("pipe dropped an item during stall");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the clipped colour-key blit core: random and directed pixels
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cckb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [IDX_SEL_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_SEL_W-1:0] REG_SPARE_HI = 3'd7;

	class blit_checker;
		logic [REG_W-1:0]   src_w, src_h, scr_w, scr_h;
		logic [PITCH_W-1:0] pitch;
		logic [PIX_W-1:0]   key_c;
		out_item_t          pending_writes[$];
		int                 fails;

		function new();
			src_w = '0;
			src_h = '0;
			scr_w = '0;
			scr_h = '0;
			pitch = '0;
			key_c = '0;
			fails = 0;
		endfunction

		function void set_reg(logic [IDX_SEL_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SOURCE_WIDTH: src_w = data[REG_W-1:0];
				REG_SOURCE_HEIGHT: src_h = data[REG_W-1:0];
				REG_SCREEN_WIDTH: scr_w = data[REG_W-1:0];
				REG_SCREEN_HEIGHT: scr_h = data[REG_W-1:0];
				REG_SCANLINE_PITCH: pitch = data[PITCH_W-1:0];
				REG_KEY_COLOR: key_c = data[PIX_W-1:0] & PIX_MASK;
				default: ;
			endcase
		endfunction

		function int clamp_dim(int v);
			return (v > MAX_DIM) ? MAX_DIM : v;
		endfunction

		function int clip_len(int start, int len, int lim);
			int stop;
			if (start >= lim) return 0;
			stop = start + len;
			if (stop > lim) stop = lim;
			return stop - start;
		endfunction

		function out_item_t predict_write(in_item_t it);
			out_item_t r;
			int        fw, fh, vw, vh;
			logic      hit;
			longint    si, sa;
			logic [PIX_W-1:0] pix;
			pix = it.pixel_value & PIX_MASK;
			fw = clip_len(int'(it.rect_src_x), int'(it.rect_width), clamp_dim(int'(src_w)));
			fh = clip_len(int'(it.rect_src_y), int'(it.rect_height), clamp_dim(int'(src_h)));
			vw = clip_len(int'(it.dest_x), fw, clamp_dim(int'(scr_w)));
			vh = clip_len(int'(it.dest_y), fh, clamp_dim(int'(scr_h)));
			hit = (int'(it.offset_x) < vw) && (int'(it.offset_y) < vh);
			r.inside_clip = hit;
			r.write_enable = hit && !(key_c != '0 && pix == key_c);
			r.source_index = '0;
			r.screen_address = '0;
			if (hit) begin
				si = (longint'(it.rect_src_y) + longint'(it.offset_y)) * longint'(src_w)
					+ longint'(it.rect_src_x) + longint'(it.offset_x);
				sa = (longint'(it.dest_y) + longint'(it.offset_y)) * longint'(pitch)
					+ longint'(it.dest_x) + longint'(it.offset_x);
				r.source_index = si[SIDX_W-1:0];
				r.screen_address = sa[SADR_W-1:0];
			end
			r.pixel_data = pix;
			return r;
		endfunction

		function void note_pixel(in_item_t it);
			pending_writes.push_back(predict_write(it));
		endfunction

		function void check_write(out_item_t got);
			out_item_t e;
			if (pending_writes.size() == 0) begin
				$error("write item with no pixel outstanding");
				fails++;
				return;
			end
			e = pending_writes.pop_front();
			if (got.inside_clip !== e.inside_clip) begin
				$error("inside_clip: expected %0d, got %0d", e.inside_clip, got.inside_clip);
				fails++;
			end
			if (got.write_enable !== e.write_enable) begin
				$error("write_enable: expected %0d, got %0d", e.write_enable, got.write_enable);
				fails++;
			end
			if (got.source_index !== e.source_index) begin
				$error("source_index: expected %0h, got %0h", e.source_index, got.source_index);
				fails++;
			end
			if (got.screen_address !== e.screen_address) begin
				$error("screen_address: expected %0h, got %0h", e.screen_address,
					got.screen_address);
				fails++;
			end
			if (got.pixel_data !== e.pixel_data) begin
				$error("pixel_data: expected %0h, got %0h", e.pixel_data, got.pixel_data);
				fails++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	in_item_t             req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	out_item_t            rsp;
	logic                 cfg_we;
	logic [IDX_SEL_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	blit_checker sb;
	bit          send_idle;
	bit          rsp_idle;
	bit          hold_req;
	int          cycle_count;

	clipped_color_key_blit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) sb.check_write(rsp);
			if (req_valid && req_ready) sb.note_pixel(req);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				rsp_ready = 1'b1;
			end else if (rsp_idle && $urandom_range(0, 3) == 0) begin
				rsp_ready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				rsp_ready = 1'b1;
			end else begin
				rsp_ready = 1'b1;
			end
		end
	end

	task automatic cfg_write(input logic [IDX_SEL_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_reg(idx, data);
	endtask

	// upper bits of the narrow registers carry noise, the block must drop them
	task automatic program_regs(input int sw, input int sh, input int cw, input int ch,
			input int pch, input logic [31:0] key);
		cfg_write(REG_SOURCE_WIDTH, ($urandom & ~32'h1FFF) | 32'(sw));
		cfg_write(REG_SOURCE_HEIGHT, ($urandom & ~32'h1FFF) | 32'(sh));
		cfg_write(REG_SCREEN_WIDTH, ($urandom & ~32'h1FFF) | 32'(cw));
		cfg_write(REG_SCREEN_HEIGHT, ($urandom & ~32'h1FFF) | 32'(ch));
		cfg_write(REG_SCANLINE_PITCH, ($urandom & ~32'h3FFF) | 32'(pch));
		cfg_write(REG_KEY_COLOR, key);
		cfg_write(REG_SPARE_LO, $urandom);
		cfg_write(REG_SPARE_HI, $urandom);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic offer_pixel(input in_item_t it);
		int gap;
		gap = (send_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = it;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending_writes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic in_item_t mk(int sx, int sy, int rw, int rh, int dx, int dy,
			int ox, int oy, logic [31:0] pix);
		in_item_t it;
		it.rect_src_x = 12'(sx);
		it.rect_src_y = 12'(sy);
		it.rect_width = 13'(rw);
		it.rect_height = 13'(rh);
		it.dest_x = 12'(dx);
		it.dest_y = 12'(dy);
		it.offset_x = 12'(ox);
		it.offset_y = 12'(oy);
		it.pixel_value = pix;
		return it;
	endfunction

	function automatic int pick_start(int lim);
		if (lim > 0 && $urandom_range(0, 7) != 0) return $urandom_range(0, lim - 1);
		return $urandom_range(0, 4095);
	endfunction

	function automatic int pick_offset(int len);
		if (len + 3 > 4095) return $urandom_range(0, 4095);
		return $urandom_range(0, len + 3);
	endfunction

	// mostly pixels of a plausible blit, the rest raw noise over the whole field range
	function automatic in_item_t random_pixel();
		in_item_t    it;
		int          rw, rh;
		logic [31:0] pix;
		if ($urandom_range(0, 3) == 0)
			return mk($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
		rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
		rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
		pix = ($urandom_range(0, 3) == 0) ? sb.key_c : $urandom;
		it = mk(pick_start(sb.clamp_dim(int'(sb.src_w))), pick_start(sb.clamp_dim(int'(sb.src_h))),
			rw, rh, pick_start(sb.clamp_dim(int'(sb.scr_w))),
			pick_start(sb.clamp_dim(int'(sb.scr_h))), pick_offset(rw), pick_offset(rh), pix);
		return it;
	endfunction

	task automatic run_pixels(input int n);
		repeat (n) offer_pixel(random_pixel());
		drain();
	endtask

	initial begin
		logic [31:0] k;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 1'b1;
		rsp_idle = 1'b1;
		hold_req = 1'b0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers still at reset: everything clipped, pixel data passes through with no write
		offer_pixel(mk(0, 0, 10, 10, 0, 0, 0, 0, 32'hA5A5A5A5));
		offer_pixel(mk(4095, 4095, 8191, 8191, 4095, 4095, 4095, 4095, 32'hFFFFFFFF));
		offer_pixel(mk(0, 0, 4096, 4096, 0, 0, 0, 0, 32'h0));
		drain();

		k = 32'h00FF00FF;
		program_regs(100, 80, 64, 48, 128, k);
		offer_pixel(mk(0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
		offer_pixel(mk(10, 5, 20, 20, 3, 4, 0, 0, 32'h12345678));
		offer_pixel(mk(10, 5, 20, 20, 3, 4, 19, 19, k));
		offer_pixel(mk(10, 5, 20, 20, 3, 4, 20, 0, k));
		offer_pixel(mk(99, 0, 4096, 1, 0, 0, 0, 0, 32'h87654321));
		offer_pixel(mk(99, 0, 4096, 1, 0, 0, 1, 0, 32'h87654321));
		offer_pixel(mk(100, 0, 10, 10, 0, 0, 0, 0, 32'h1));
		offer_pixel(mk(4095, 4095, 4096, 4096, 0, 0, 0, 0, 32'h2));
		offer_pixel(mk(0, 0, 4096, 4096, 0, 0, 63, 47, 32'hFFFFFFFF));
		offer_pixel(mk(0, 0, 4096, 4096, 0, 0, 64, 47, 32'hFFFFFFFF));
		offer_pixel(mk(0, 0, 4096, 4096, 63, 47, 0, 0, 32'h55AA55AA));
		offer_pixel(mk(0, 0, 4096, 4096, 64, 0, 0, 0, 32'h55AA55AA));
		offer_pixel(mk(0, 0, 4096, 4096, 0, 48, 0, 0, 32'h55AA55AA));
		offer_pixel(mk(0, 0, 4096, 4096, 4095, 4095, 0, 0, 32'h3));
		offer_pixel(mk(0, 79, 50, 50, 0, 0, 0, 0, 32'h4));
		offer_pixel(mk(0, 79, 50, 50, 0, 0, 0, 1, 32'h4));
		offer_pixel(mk(0, 0, 50, 50, 0, 0, 4095, 4095, 32'h5));
		offer_pixel(mk(0, 0, 8191, 8191, 0, 0, 5, 5, 32'h0));
		offer_pixel(mk(5, 5, 10, 10, 5, 5, 9, 9, k));
		offer_pixel(mk(5, 5, 10, 10, 5, 5, 9, 10, k));
		drain();
		run_pixels(180);

		// dimensions past the maximum saturate; long receiver hold-off fills the pipe
		program_regs(8191, 8191, 8191, 8191, 16383, 32'hFFFFFFFF);
		hold_req = 1'b1;
		offer_pixel(mk(4095, 4095, 8191, 8191, 4095, 4095, 0, 0, 32'hFFFFFFFF));
		offer_pixel(mk(4095, 4095, 8191, 8191, 4095, 4095, 0, 0, 32'hFFFFFFFE));
		offer_pixel(mk(0, 0, 8191, 8191, 0, 0, 4095, 4095, 32'h0));
		run_pixels(150);

		program_regs(4096, 4096, 4096, 4096, 8192, 32'h0);
		offer_pixel(mk(0, 0, 4096, 4096, 0, 0, 4095, 4095, 32'h0));
		run_pixels(150);

		program_regs(1, 1, 1, 1, 1, 32'h000000FF);
		offer_pixel(mk(0, 0, 1, 1, 0, 0, 0, 0, 32'h000000FF));
		run_pixels(100);

		program_regs($urandom_range(16, 600), $urandom_range(16, 600), $urandom_range(16, 600),
			$urandom_range(16, 600), $urandom_range(0, 16383), $urandom);
		run_pixels(150);

		send_idle = 1'b0;
		rsp_idle = 1'b0;
		program_regs($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
			$urandom_range(0, 8191), $urandom_range(0, 16383),
			($urandom_range(0, 1) == 0) ? 32'h0 : $urandom);
		run_pixels(200);

		repeat (5) @(posedge clk);
		if (sb.fails == 0 && sb.pending_writes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
